FILE: design/ppou_pkg.sv
// Shared types, constants and the arctangent table of the pose composition pipeline.
package ppou_pkg;

	localparam int unsigned ATAN_ENTRIES = 24;
	localparam int unsigned CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] INV_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0]         px;
		logic signed [31:0]         py;
		logic signed [31:0]         dx;
		logic signed [31:0]         dy;
		logic [15:0]                heading;
		logic                       flip;
		logic signed [CORDIC_W-1:0] cx;
		logic signed [CORDIC_W-1:0] cy;
		logic [31:0]                z;
	} pipe_t;

	function automatic logic [31:0] atan_entry(input int unsigned idx);
		logic [31:0] v;
		unique case (idx)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: design/ppou_if.sv
// Valid/ready channel interfaces for odometry steps and composed poses.
interface ppou_step_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] prev_x;
	logic signed [31:0] prev_y;
	logic signed [15:0] prev_heading;
	logic signed [31:0] odo_dx;
	logic signed [31:0] odo_dy;
	logic signed [15:0] odo_dheading;

	modport source (
		output valid, prev_x, prev_y, prev_heading, odo_dx, odo_dy, odo_dheading,
		input  ready
	);
	modport sink (
		input  valid, prev_x, prev_y, prev_heading, odo_dx, odo_dy, odo_dheading,
		output ready
	);
endinterface

interface ppou_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic signed [15:0] new_heading;
	logic               saturated;

	modport source (
		output valid, new_x, new_y, new_heading, saturated,
		input  ready
	);
	modport sink (
		input  valid, new_x, new_y, new_heading, saturated,
		output ready
	);
endinterface

FILE: design/ppou_cordic_stage.sv
// One registered CORDIC micro-rotation stage with its own valid bit.
module ppou_cordic_stage
	import ppou_pkg::*;
#(
	parameter int unsigned SHIFT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  pipe_t up_data,
	output logic  dn_valid,
	input  logic  dn_ready,
	output pipe_t dn_data
);

	localparam logic [31:0] ATAN = atan_entry(SHIFT);

	logic  valid_s;
	pipe_t stage_s;
	pipe_t next;
	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;

	assign up_ready = !valid_s || dn_ready;
	assign dn_valid = valid_s;
	assign dn_data  = stage_s;

	always_comb begin
		next = up_data;
		xs = up_data.cx >>> SHIFT;
		ys = up_data.cy >>> SHIFT;
		if (!up_data.z[31]) begin
			next.cx = up_data.cx - ys;
			next.cy = up_data.cy + xs;
			next.z  = up_data.z - ATAN;
		end else begin
			next.cx = up_data.cx + ys;
			next.cy = up_data.cy - xs;
			next.z  = up_data.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (up_ready) begin
			valid_s <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			stage_s <= next;
		end
	end

endmodule

FILE: design/planar_pose_odometry_update.sv
// Planar pose composition: rotates the odometry step by the heading and adds it to the pose.
// Path: entry register, CORDIC stages, rotate, product, accumulate and result registers.
// Throughput: one beat per cycle when not stalled; one micro-rotation per CORDIC stage.
// Every stage has its own valid bit, so empty stages fill while the output stalls.
// Reset clears only the valid bits; payload registers are not reset.
module planar_pose_odometry_update
	import ppou_pkg::*;
#(
	parameter int unsigned TRIG_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ppou_step_if.sink    step,
	ppou_pose_if.source  pose
);

	localparam int unsigned ITERS =
		(TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;
	localparam int unsigned PW = 2 * CORDIC_W - 2 + 32;
	localparam int unsigned TW = PW + 2;

	typedef struct packed {
		logic signed [31:0]         px;
		logic signed [31:0]         py;
		logic signed [31:0]         dx;
		logic signed [31:0]         dy;
		logic [15:0]                heading;
		logic signed [CORDIC_W-1:0] c;
		logic signed [CORDIC_W-1:0] s;
	} rot_t;

	typedef struct packed {
		logic signed [31:0]   px;
		logic signed [31:0]   py;
		logic [15:0]          heading;
		logic signed [PW-1:0] cdx;
		logic signed [PW-1:0] sdy;
		logic signed [PW-1:0] sdx;
		logic signed [PW-1:0] cdy;
	} prod_t;

	typedef struct packed {
		logic [15:0]          heading;
		logic signed [TW-1:0] tx;
		logic signed [TW-1:0] ty;
	} acc_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        heading;
		logic               sat;
	} res_t;

	logic  cord_valid [ITERS+1];
	logic  cord_ready [ITERS+1];
	pipe_t cord_data  [ITERS+1];

	logic  ent_valid_s;
	pipe_t ent_s;
	logic  ent_ready;
	pipe_t ent_next;

	logic  rot_valid_s;
	rot_t  rot_s;
	logic  rot_ready;

	logic  prd_valid_s;
	prod_t prd_s;
	logic  prd_ready;

	logic  acc_valid_s;
	acc_t  acc_s;
	logic  acc_ready;

	logic  res_valid_s;
	res_t  res_s;
	logic  res_ready;

	logic signed [TW-TW+37:0] rx;
	logic signed [TW-TW+37:0] ry;
	logic                     sat_x;
	logic                     sat_y;
	logic signed [31:0]       clamp_x;
	logic signed [31:0]       clamp_y;

	assign res_ready = !res_valid_s || pose.ready;
	assign acc_ready = !acc_valid_s || res_ready;
	assign prd_ready = !prd_valid_s || acc_ready;
	assign rot_ready = !rot_valid_s || prd_ready;
	assign cord_ready[ITERS] = rot_ready;
	assign ent_ready = !ent_valid_s || cord_ready[0];
	assign step.ready = ent_ready;

	always_comb begin
		ent_next.px      = step.prev_x;
		ent_next.py      = step.prev_y;
		ent_next.dx      = step.odo_dx;
		ent_next.dy      = step.odo_dy;
		ent_next.heading = 16'(step.prev_heading + step.odo_dheading);
		ent_next.flip    = step.prev_heading[15] ^ step.prev_heading[14];
		ent_next.cx      = INV_GAIN;
		ent_next.cy      = '0;
		ent_next.z       = {step.prev_heading[15] ^ ent_next.flip,
			step.prev_heading[14:0], 16'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_s <= 1'b0;
		end else if (ent_ready) begin
			ent_valid_s <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_ready && step.valid) begin
			ent_s <= ent_next;
		end
	end

	assign cord_valid[0] = ent_valid_s;
	assign cord_data[0]  = ent_s;

	for (genvar k = 0; k < ITERS; k++) begin : g_cordic
		ppou_cordic_stage #(
			.SHIFT (k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cord_valid[k]),
			.up_ready (cord_ready[k]),
			.up_data  (cord_data[k]),
			.dn_valid (cord_valid[k+1]),
			.dn_ready (cord_ready[k+1]),
			.dn_data  (cord_data[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_valid_s <= 1'b0;
			prd_valid_s <= 1'b0;
			acc_valid_s <= 1'b0;
			res_valid_s <= 1'b0;
		end else begin
			if (rot_ready) begin
				rot_valid_s <= cord_valid[ITERS];
			end
			if (prd_ready) begin
				prd_valid_s <= rot_valid_s;
			end
			if (acc_ready) begin
				acc_valid_s <= prd_valid_s;
			end
			if (res_ready) begin
				res_valid_s <= acc_valid_s;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rot_ready && cord_valid[ITERS]) begin
			rot_s.px      <= cord_data[ITERS].px;
			rot_s.py      <= cord_data[ITERS].py;
			rot_s.dx      <= cord_data[ITERS].dx;
			rot_s.dy      <= cord_data[ITERS].dy;
			rot_s.heading <= cord_data[ITERS].heading;
			rot_s.c <= cord_data[ITERS].flip ? -cord_data[ITERS].cx : cord_data[ITERS].cx;
			rot_s.s <= cord_data[ITERS].flip ? -cord_data[ITERS].cy : cord_data[ITERS].cy;
		end
	end

	always_ff @(posedge clk) begin
		if (prd_ready && rot_valid_s) begin
			prd_s.px      <= rot_s.px;
			prd_s.py      <= rot_s.py;
			prd_s.heading <= rot_s.heading;
			prd_s.cdx     <= rot_s.c * rot_s.dx;
			prd_s.sdy     <= rot_s.s * rot_s.dy;
			prd_s.sdx     <= rot_s.s * rot_s.dx;
			prd_s.cdy     <= rot_s.c * rot_s.dy;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_ready && prd_valid_s) begin
			acc_s.heading <= prd_s.heading;
			acc_s.tx <= (TW'(prd_s.px) <<< 30) + TW'(prd_s.cdx) - TW'(prd_s.sdy)
				+ (TW'(1) <<< 29);
			acc_s.ty <= (TW'(prd_s.py) <<< 30) + TW'(prd_s.sdx) + TW'(prd_s.cdy)
				+ (TW'(1) <<< 29);
		end
	end

	always_comb begin
		rx = acc_s.tx[67:30];
		ry = acc_s.ty[67:30];
		sat_x = (rx[37:31] != {7{rx[37]}});
		sat_y = (ry[37:31] != {7{ry[37]}});
		clamp_x = sat_x ? {rx[37], {31{!rx[37]}}} : rx[31:0];
		clamp_y = sat_y ? {ry[37], {31{!ry[37]}}} : ry[31:0];
	end

	always_ff @(posedge clk) begin
		if (res_ready && acc_valid_s) begin
			res_s.x       <= clamp_x;
			res_s.y       <= clamp_y;
			res_s.heading <= acc_s.heading;
			res_s.sat     <= sat_x || sat_y;
		end
	end

	assign pose.valid       = res_valid_s;
	assign pose.new_x       = res_s.x;
	assign pose.new_y       = res_s.y;
	assign pose.new_heading = res_s.heading;
	assign pose.saturated   = res_s.sat;

endmodule
